// File: design/grid_maze_dfs_solver_top_defines.svh
// assertion helpers, clocked on clock, disabled during reset
`ifndef GRID_MAZE_DFS_SOLVER_TOP_DEFINES_SVH
`define GRID_MAZE_DFS_SOLVER_TOP_DEFINES_SVH

// same-cycle implication
`define GMDS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GMDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/gmds_pkg.sv
package gmds_pkg;

   localparam int REQ_TYPE_W = 2;
   localparam int POS_W      = 5;
   localparam int CODE_W     = 3;
   localparam int CFG_W      = 6;
   localparam int CSR_IDX_W  = 2;

   localparam logic [REQ_TYPE_W-1:0] REQ_LOAD  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SOLVE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   localparam logic [CODE_W-1:0] CODE_EMPTY = 3'd0;
   localparam logic [CODE_W-1:0] CODE_WALL  = 3'd1;
   localparam logic [CODE_W-1:0] CODE_PATH  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_BEGIN = 3'd3;
   localparam logic [CODE_W-1:0] CODE_GOAL  = 3'd4;

   localparam logic [2:0] DIR_DOWN  = 3'd0;
   localparam logic [2:0] DIR_RIGHT = 3'd1;
   localparam logic [2:0] DIR_UP    = 3'd2;
   localparam logic [2:0] DIR_LEFT  = 3'd3;
   localparam logic [2:0] DIR_DONE  = 3'd4;

   localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_READ_WAIT = 13'b0000000000010,
      ST_SCAN      = 13'b0000000000100,
      ST_SCAN_END  = 13'b0000000001000,
      ST_SCAN_DONE = 13'b0000000010000,
      ST_START     = 13'b0000000100000,
      ST_TE_RD     = 13'b0000001000000,
      ST_TE_CK     = 13'b0000010000000,
      ST_EXPLORE   = 13'b0000100000000,
      ST_EX_CK     = 13'b0001000000000,
      ST_POP_WAIT  = 13'b0010000000000,
      ST_FINISH    = 13'b0100000000000,
      ST_FAIL      = 13'b1000000000000
   } state_type;

endpackage

// File: design/gmds_req_if.sv
interface gmds_req_if import gmds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [POS_W-1:0]      row;
   logic [POS_W-1:0]      col;
   logic [CODE_W-1:0]     cell_code;

   modport source (output valid, req_type, row, col, cell_code, input ready);
   modport sink (input valid, req_type, row, col, cell_code, output ready);
endinterface

// File: design/gmds_rsp_if.sv
interface gmds_rsp_if import gmds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] read_code;
   logic              solved;

   modport source (output valid, read_code, solved, input ready);
   modport sink (input valid, read_code, solved, output ready);
endinterface

// File: design/gmds_csr_if.sv
interface gmds_csr_if import gmds_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: design/gmds_ram.sv
module gmds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: design/grid_maze_dfs_solver_top.sv
// grid maze solver, depth-first with backtracking
// req_bus takes one word per request: load cell, solve, or read cell.
// rsp_bus returns exactly one word per request, in order: read_code holds
// the cell read (wall outside the grid, 0 for other requests) and solved
// the outcome of the latest solve.
// csr_bus writes rows_in_use (index 0) and cols_in_use (index 1); write only
// while no request is in flight.
// a load answers straight from idle, a read waits on the grid memory in ST_READ_WAIT.
// a solve first scans the grid at one cell per cycle (and fails when begin or
// end is missing), then walks: each probe of a neighbor uses the grid memory
// read port, as does each end check; each backtrack pops the stack.
// one request is handled at a time; the grid memory port sets the pace.
// the next request is taken while a result waits, as long as that result is
// taken in the same cycle; a stalled rsp_bus holds the block otherwise.
// reset clears the sizes to 32x32, the solved flag and the control state.
// grid contents are undefined after reset until loaded.
`include "grid_maze_dfs_solver_top_defines.svh"

module grid_maze_dfs_solver_top import gmds_pkg::*; #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic       clock,
   input  logic       reset,
   gmds_req_if.sink   req_bus,
   gmds_rsp_if.source rsp_bus,
   gmds_csr_if.sink   csr_bus
);

   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int SW = RW + CW;
   localparam int CELLS = 1 << SW;
   localparam int MW = (RW > CW) ? RW : CW;
   localparam int EW = ((MW > CFG_W) ? MW : CFG_W) + 2;
   localparam int ENT_W = SW + 3;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic              solved_ff, solved_in;
   logic [SW:0]       sp_ff, sp_in;
   logic              bf_ff, bf_in, ef_ff, ef_in;
   logic [RW-1:0]     br_ff, br_in, sr_ff, sr_in, pr_ff, pr_in, tr_ff, tr_in, cr_ff, cr_in;
   logic [CW-1:0]     bc_ff, bc_in, sc_ff, sc_in, pc_ff, pc_in, tc_ff, tc_in, cc_ff, cc_in;
   logic              pv_ff, pv_in, tb_ff, tb_in;
   logic [2:0]        td_ff, td_in, cd_ff, cd_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic              rsp_solved_ff, rsp_solved_in;

   logic [EW-1:0]     eff_r, eff_c;
   logic              acc, in_grid;
   logic [RW-1:0]     in_r;
   logic [CW-1:0]     in_c;
   logic [SW:0]       t_nb, c_nb;

   logic              g_we;
   logic [SW-1:0]     g_waddr, g_raddr;
   logic [CODE_W-1:0] g_wdata, g_rdata;
   logic              s_we;
   logic [SW-1:0]     s_waddr, s_raddr;
   logic [ENT_W-1:0]  s_wdata, s_rdata;

   function automatic logic [SW:0] nbr(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                       input logic [2:0] d, input logic [EW-1:0] er,
                                       input logic [EW-1:0] ec);
      logic          ok;
      logic [RW-1:0] nr;
      logic [CW-1:0] nc;
      ok = 1'b0;
      nr = r;
      nc = c;
      case (d)
         DIR_DOWN: begin
            if (EW'(r) + EW'(1) < er) begin
               ok = 1'b1;
               nr = r + RW'(1);
            end
         end
         DIR_RIGHT: begin
            if (EW'(c) + EW'(1) < ec) begin
               ok = 1'b1;
               nc = c + CW'(1);
            end
         end
         DIR_UP: begin
            if (r != '0) begin
               ok = 1'b1;
               nr = r - RW'(1);
            end
         end
         DIR_LEFT: begin
            if (c != '0) begin
               ok = 1'b1;
               nc = c - CW'(1);
            end
         end
         default: ok = 1'b0;
      endcase
      return {ok, nr, nc};
   endfunction

   assign eff_r = (EW'(rows_ff) > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : EW'(rows_ff);
   assign eff_c = (EW'(cols_ff) > EW'(MAX_COLS)) ? EW'(MAX_COLS) : EW'(cols_ff);

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign acc = req_bus.valid && req_bus.ready;
   assign in_grid = (EW'(req_bus.row) < eff_r) && (EW'(req_bus.col) < eff_c);
   assign in_r = RW'(req_bus.row);
   assign in_c = CW'(req_bus.col);

   assign t_nb = nbr(tr_ff, tc_ff, td_ff, eff_r, eff_c);
   assign c_nb = nbr(cr_ff, cc_ff, cd_ff, eff_r, eff_c);

   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.read_code = rsp_code_ff;
   assign rsp_bus.solved = rsp_solved_ff;

   gmds_ram #(.WIDTH(CODE_W), .DEPTH(CELLS)) u_grid (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (g_wdata),
      .rd_addr (g_raddr),
      .rd_data (g_rdata)
   );

   gmds_ram #(.WIDTH(ENT_W), .DEPTH(CELLS)) u_stack (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   always_comb begin
      state_in = state_ff;
      rows_in = rows_ff;
      cols_in = cols_ff;
      solved_in = solved_ff;
      sp_in = sp_ff;
      bf_in = bf_ff;
      ef_in = ef_ff;
      br_in = br_ff;
      bc_in = bc_ff;
      sr_in = sr_ff;
      sc_in = sc_ff;
      pr_in = pr_ff;
      pc_in = pc_ff;
      pv_in = 1'b0;
      tr_in = tr_ff;
      tc_in = tc_ff;
      td_in = td_ff;
      tb_in = tb_ff;
      cr_in = cr_ff;
      cc_in = cc_ff;
      cd_in = cd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_code_in = rsp_code_ff;
      rsp_solved_in = rsp_solved_ff;
      g_we = 1'b0;
      g_waddr = {tr_ff, tc_ff};
      g_wdata = CODE_PATH;
      g_raddr = {tr_ff, tc_ff};
      s_we = 1'b0;
      s_waddr = SW'(sp_ff);
      s_wdata = {cr_ff, cc_ff, cd_ff};
      s_raddr = SW'(sp_ff - 1'b1);

      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ROWS: rows_in = csr_bus.data;
            CSR_COLS: cols_in = csr_bus.data;
            default: ;
         endcase
      end

      // scan result of the previous cycle's read
      if (pv_ff) begin
         if (g_rdata == CODE_BEGIN) begin
            bf_in = 1'b1;
            br_in = pr_ff;
            bc_in = pc_ff;
         end
         if (g_rdata == CODE_GOAL) begin
            ef_in = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               rsp_valid_in = 1'b1;
               rsp_code_in = CODE_EMPTY;
               rsp_solved_in = solved_ff;
               case (req_bus.req_type)
                  REQ_LOAD: begin
                     g_we = in_grid;
                     g_waddr = {in_r, in_c};
                     g_wdata = req_bus.cell_code;
                  end
                  REQ_SOLVE: begin
                     bf_in = 1'b0;
                     ef_in = 1'b0;
                     sr_in = '0;
                     sc_in = '0;
                     if (eff_r == '0 || eff_c == '0) begin
                        solved_in = 1'b0;
                        rsp_solved_in = 1'b0;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_READ: begin
                     if (in_grid) begin
                        g_raddr = {in_r, in_c};
                        rsp_valid_in = 1'b0;
                        state_in = ST_READ_WAIT;
                     end else begin
                        rsp_code_in = CODE_WALL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_code_in = g_rdata;
            rsp_solved_in = solved_ff;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            g_raddr = {sr_ff, sc_ff};
            pv_in = 1'b1;
            pr_in = sr_ff;
            pc_in = sc_ff;
            if (EW'(sc_ff) + EW'(1) == eff_c) begin
               sc_in = '0;
               if (EW'(sr_ff) + EW'(1) == eff_r) begin
                  state_in = ST_SCAN_END;
               end else begin
                  sr_in = sr_ff + RW'(1);
               end
            end else begin
               sc_in = sc_ff + CW'(1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_SCAN_DONE;
         end
         ST_SCAN_DONE: begin
            if (bf_ff && ef_ff) begin
               state_in = ST_START;
            end else begin
               state_in = ST_FAIL;
            end
         end
         ST_START: begin
            g_we = 1'b1;
            g_waddr = {br_ff, bc_ff};
            g_wdata = CODE_PATH;
            tr_in = br_ff;
            tc_in = bc_ff;
            td_in = DIR_DOWN;
            tb_in = 1'b1;
            state_in = ST_TE_RD;
         end
         ST_TE_RD: begin
            if (td_ff == DIR_DONE) begin
               // no goal next to the new cell: it becomes the cursor, the old cursor is pushed
               if (!tb_ff) begin
                  s_we = 1'b1;
                  sp_in = sp_ff + 1'b1;
               end else begin
                  sp_in = '0;
               end
               cr_in = tr_ff;
               cc_in = tc_ff;
               cd_in = DIR_DOWN;
               state_in = ST_EXPLORE;
            end else if (t_nb[SW]) begin
               g_raddr = t_nb[SW-1:0];
               state_in = ST_TE_CK;
            end else begin
               td_in = td_ff + 3'd1;
            end
         end
         ST_TE_CK: begin
            if (g_rdata == CODE_GOAL) begin
               state_in = ST_FINISH;
            end else begin
               td_in = td_ff + 3'd1;
               state_in = ST_TE_RD;
            end
         end
         ST_EXPLORE: begin
            if (cd_ff == DIR_DONE) begin
               g_we = 1'b1;
               g_waddr = {cr_ff, cc_ff};
               g_wdata = CODE_EMPTY;
               if (sp_ff == '0) begin
                  state_in = ST_FAIL;
               end else begin
                  sp_in = sp_ff - 1'b1;
                  state_in = ST_POP_WAIT;
               end
            end else if (c_nb[SW]) begin
               g_raddr = c_nb[SW-1:0];
               tr_in = c_nb[SW-1:CW];
               tc_in = c_nb[CW-1:0];
               state_in = ST_EX_CK;
            end else begin
               cd_in = cd_ff + 3'd1;
            end
         end
         ST_EX_CK: begin
            cd_in = cd_ff + 3'd1;
            if (g_rdata == CODE_EMPTY) begin
               g_we = 1'b1;
               g_waddr = {tr_ff, tc_ff};
               g_wdata = CODE_PATH;
               td_in = DIR_DOWN;
               tb_in = 1'b0;
               state_in = ST_TE_RD;
            end else begin
               state_in = ST_EXPLORE;
            end
         end
         ST_POP_WAIT: begin
            {cr_in, cc_in, cd_in} = s_rdata;
            state_in = ST_EXPLORE;
         end
         ST_FINISH: begin
            g_we = 1'b1;
            g_waddr = {br_ff, bc_ff};
            g_wdata = CODE_BEGIN;
            solved_in = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_code_in = CODE_EMPTY;
            rsp_solved_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FAIL: begin
            solved_in = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_code_in = CODE_EMPTY;
            rsp_solved_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rows_ff <= CFG_RESET;
         cols_ff <= CFG_RESET;
         solved_ff <= 1'b0;
         sp_ff <= '0;
         bf_ff <= 1'b0;
         ef_ff <= 1'b0;
         pv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         solved_ff <= solved_in;
         sp_ff <= sp_in;
         bf_ff <= bf_in;
         ef_ff <= ef_in;
         pv_ff <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      br_ff <= br_in;
      bc_ff <= bc_in;
      sr_ff <= sr_in;
      sc_ff <= sc_in;
      pr_ff <= pr_in;
      pc_ff <= pc_in;
      tr_ff <= tr_in;
      tc_ff <= tc_in;
      td_ff <= td_in;
      tb_ff <= tb_in;
      cr_ff <= cr_in;
      cc_ff <= cc_in;
      cd_ff <= cd_in;
      rsp_code_ff <= rsp_code_in;
      rsp_solved_ff <= rsp_solved_in;
   end

   `GMDS_ASSERT_SAME(a_stack_bound, state_ff == ST_EXPLORE, sp_ff < (SW+1)'(CELLS),
                     "stack overrun")
   `GMDS_ASSERT_SAME(a_cursor_on_grid, state_ff == ST_EXPLORE,
                     (EW'(cr_ff) < eff_r) && (EW'(cc_ff) < eff_c), "cursor off grid")
   `GMDS_ASSERT_NEXT(a_solve_scans,
                     acc && req_bus.req_type == REQ_SOLVE && eff_r != '0 && eff_c != '0,
                     state_ff == ST_SCAN && !rsp_valid_ff, "solve did not start scan")

endmodule

// File: verif/grid_maze_dfs_solver_top_tb.sv
`timescale 1ns / 1ps

module grid_maze_dfs_solver_top_tb;
   import gmds_pkg::*;

   localparam int NCOLS = 32;
   localparam int NCELLS = 1024;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

   typedef struct {
      logic [CODE_W-1:0] read_code;
      logic              solved;
   } rsp_word_type;

   class maze_scoreboard;
      logic [CODE_W-1:0] grid [NCELLS];
      logic [CFG_W-1:0]  rows;
      logic [CFG_W-1:0]  cols;
      logic              solved;
      rsp_word_type      pending [$];
      int                fails;

      function new();
         rows = CFG_RESET;
         cols = CFG_RESET;
         solved = 1'b0;
         fails = 0;
         foreach (grid[i]) grid[i] = CODE_EMPTY;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
         if (idx == CSR_ROWS) rows = val;
         else if (idx == CSR_COLS) cols = val;
      endfunction

      function int eff_rows();
         return (rows > 32) ? 32 : int'(rows);
      endfunction

      function int eff_cols();
         return (cols > 32) ? 32 : int'(cols);
      endfunction

      function bit step_to(int idx, int d, output int nxt);
         int r;
         int c;
         r = idx / NCOLS;
         c = idx % NCOLS;
         nxt = 0;
         if (d == DIR_DOWN) begin
            if (r + 1 >= eff_rows()) return 0;
            r++;
         end else if (d == DIR_RIGHT) begin
            if (c + 1 >= eff_cols()) return 0;
            c++;
         end else if (d == DIR_UP) begin
            if (r == 0) return 0;
            r--;
         end else begin
            if (c == 0) return 0;
            c--;
         end
         nxt = r * NCOLS + c;
         return 1;
      endfunction

      function bit next_to_goal(int idx);
         int n;
         for (int d = 0; d < 4; d++)
            if (step_to(idx, d, n) && grid[n] == CODE_GOAL) return 1;
         return 0;
      endfunction

      function bit walk(int start);
         int stk [$];
         int e;
         int idx;
         int n;
         bit moved;
         grid[start] = CODE_PATH;
         if (next_to_goal(start)) return 1;
         stk.push_back(start << 3);
         while (stk.size() > 0) begin
            e = stk[$];
            idx = e >> 3;
            moved = 0;
            for (int d = e & 7; d < 4; d++) begin
               if (step_to(idx, d, n) && grid[n] == CODE_EMPTY) begin
                  stk[stk.size() - 1] = (idx << 3) | (d + 1);
                  grid[n] = CODE_PATH;
                  if (next_to_goal(n)) return 1;
                  if (stk.size() < NCELLS) stk.push_back(n << 3);
                  moved = 1;
                  break;
               end
            end
            if (!moved) begin
               grid[idx] = CODE_EMPTY;
               void'(stk.pop_back());
            end
         end
         return 0;
      endfunction

      function void do_solve();
         bit has_b;
         bit has_e;
         int bcell;
         has_b = 0;
         has_e = 0;
         bcell = 0;
         for (int r = 0; r < eff_rows(); r++)
            for (int c = 0; c < eff_cols(); c++) begin
               if (grid[r * NCOLS + c] == CODE_BEGIN) begin
                  has_b = 1;
                  bcell = r * NCOLS + c;
               end
               if (grid[r * NCOLS + c] == CODE_GOAL) has_e = 1;
            end
         if (!has_b || !has_e) begin
            solved = 0;
            return;
         end
         if (walk(bcell)) begin
            grid[bcell] = CODE_BEGIN;
            solved = 1;
         end else begin
            solved = 0;
         end
      endfunction

      function void note_req(logic [REQ_TYPE_W-1:0] kind, logic [POS_W-1:0] r,
                             logic [POS_W-1:0] c, logic [CODE_W-1:0] code);
         rsp_word_type w;
         bit in_grid;
         in_grid = (int'(r) < eff_rows()) && (int'(c) < eff_cols());
         w.read_code = CODE_EMPTY;
         if (kind == REQ_LOAD) begin
            if (in_grid) grid[r * NCOLS + c] = code;
         end else if (kind == REQ_SOLVE) begin
            do_solve();
         end else if (kind == REQ_READ) begin
            w.read_code = in_grid ? grid[r * NCOLS + c] : CODE_WALL;
         end
         w.solved = solved;
         pending.push_back(w);
      endfunction

      function void check_rsp(logic [CODE_W-1:0] rc, logic s);
         rsp_word_type w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word read_code=%0d solved=%0d", $time, rc, s);
            fails++;
            return;
         end
         w = pending.pop_front();
         if (rc !== w.read_code) begin
            $display("%0t: read_code expected %0d actual %0d", $time, w.read_code, rc);
            fails++;
         end
         if (s !== w.solved) begin
            $display("%0t: solved expected %0d actual %0d", $time, w.solved, s);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   hold_long = 0;
   bit   calm = 0;

   gmds_req_if req_bus ();
   gmds_rsp_if rsp_bus ();
   gmds_csr_if csr_bus ();

   maze_scoreboard sb = new();

   grid_maze_dfs_solver_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_req(req_bus.req_type, req_bus.row, req_bus.col, req_bus.cell_code);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_rsp(rsp_bus.read_code, rsp_bus.solved);
      end
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_long = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_word(logic [REQ_TYPE_W-1:0] kind, int r, int c, int code);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= kind;
      req_bus.row       <= POS_W'(r);
      req_bus.col       <= POS_W'(c);
      req_bus.cell_code <= CODE_W'(code);
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= CFG_W'(val);
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
      sb.set_reg(idx, CFG_W'(val));
   endtask

   task automatic set_size(int r, int c);
      drain();
      write_csr(CSR_ROWS, r);
      write_csr(CSR_COLS, c);
   endtask

   // random maze on an r x c grid, usually with one begin and one end
   task automatic run_maze(int r, int c, bit broken);
      int nb;
      int ne;
      set_size(r, c);
      for (int i = 0; i < r; i++)
         for (int j = 0; j < c; j++)
            send_word(REQ_LOAD, i, j,
                      ($urandom_range(0, 9) < 3) ? int'(CODE_WALL) : int'(CODE_EMPTY));
      nb = broken ? $urandom_range(0, 2) : 1;
      ne = broken ? $urandom_range(0, 2) : 1;
      for (int k = 0; k < nb; k++)
         send_word(REQ_LOAD, $urandom_range(0, r - 1), $urandom_range(0, c - 1),
                   int'(CODE_BEGIN));
      for (int k = 0; k < ne; k++)
         send_word(REQ_LOAD, $urandom_range(0, r - 1), $urandom_range(0, c - 1),
                   int'(CODE_GOAL));
      send_word(REQ_SOLVE, 0, 0, 0);
      repeat ($urandom_range(2, 5))
         send_word(REQ_READ, $urandom_range(0, r), $urandom_range(0, c), 0);
      if ($urandom_range(0, 1)) send_word(REQ_SOLVE, 0, 0, 0);
   endtask

   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= REQ_LOAD;
      req_bus.row       <= '0;
      req_bus.col       <= '0;
      req_bus.cell_code <= CODE_EMPTY;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_ROWS;
      csr_bus.data      <= CFG_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // small grid, every cell of it loaded so no unwritten cell is ever touched
      set_size(4, 4);
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            send_word(REQ_LOAD, i, j, int'(CODE_EMPTY));

      send_word(REQ_SOLVE, 0, 0, 0);
      send_word(REQ_LOAD, 3, 3, 7);
      send_word(REQ_READ, 3, 3, 0);
      send_word(REQ_LOAD, 3, 3, 5);
      send_word(REQ_READ, 3, 3, 0);
      send_word(REQ_UNKNOWN, 3, 3, 7);
      send_word(REQ_LOAD, 3, 3, int'(CODE_EMPTY));
      send_word(REQ_LOAD, 0, 0, int'(CODE_BEGIN));
      send_word(REQ_LOAD, 3, 3, int'(CODE_GOAL));
      send_word(REQ_SOLVE, 0, 0, 0);
      send_word(REQ_READ, 0, 0, 0);
      send_word(REQ_READ, 1, 0, 0);
      send_word(REQ_READ, 3, 3, 0);
      send_word(REQ_READ, 3, 2, 0);

      set_size(63, 63);
      send_word(REQ_LOAD, 31, 31, int'(CODE_WALL));
      send_word(REQ_READ, 31, 31, 0);
      set_size(1, 4);
      send_word(REQ_READ, 1, 0, 0);
      send_word(REQ_LOAD, 0, 1, int'(CODE_BEGIN));
      send_word(REQ_LOAD, 0, 2, int'(CODE_GOAL));
      send_word(REQ_LOAD, 0, 3, int'(CODE_GOAL));
      send_word(REQ_SOLVE, 0, 0, 0);
      send_word(REQ_READ, 0, 1, 0);
      set_size(0, 0);
      send_word(REQ_SOLVE, 0, 0, 0);
      send_word(REQ_READ, 0, 0, 0);
      set_size(2, 1);
      send_word(REQ_READ, 0, 0, 0);

      for (int m = 0; m < 5; m++) begin
         if (m == 1) begin
            drain();
            hold_long = 1;
         end
         if (m == 4) calm = 1;
         run_maze($urandom_range(2, 4), $urandom_range(2, 4), ($urandom_range(0, 3) == 0));
         repeat ($urandom_range(2, 6))
            send_word(REQ_TYPE_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 7));
      end

      drain();
      repeat (50) @(posedge clock);
      if (sb.fails == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/gmds_pkg.sv
design/gmds_req_if.sv
design/gmds_rsp_if.sv
design/gmds_csr_if.sv
design/gmds_ram.sv
design/grid_maze_dfs_solver_top.sv
verif/grid_maze_dfs_solver_top_tb.sv
